// File: rtl/cbs_pkg.sv
package cbs_pkg;

   // Default coordinate width: signed fixed point, 16 fraction bits by default.
   localparam int COORD_WIDTH_DEF = 32;

   // Default number of fraction bits of the split parameter t.
   localparam int T_BITS_DEF = 16;

   // Every item carries one curve in two dimensions.
   localparam int AXES = 2;
   localparam int AXIS_X = 0;
   localparam int AXIS_Y = 1;

endpackage

// File: rtl/cubic_bezier_split.sv
// Cubic Bezier split at parameter t by de Casteljau subdivision, fixed point.
// The request stream carries one curve segment per item: t (2^T_BITS means one,
// larger values act as one), the start point with its outgoing handle offset and
// the end point with its incoming handle offset, all signed fixed point.
// The response stream returns one item per request: the point on the curve at t
// and its new incoming and outgoing handles as offsets from that point, each
// saturated to the coordinate width. Responses keep the order of requests.
// The pipeline has 8 register stages: one input stage that forms the absolute
// control points, three interpolation levels of two stages each (subtract and
// multiply by t, then floor and add), and one output stage that forms the offsets
// and saturates. While rsp_tready stays high, the pipeline takes one item per
// cycle; each stage holds one item and passes it on when the next stage is free.
// When the receiver holds rsp_tready low, the pipeline fills up and then
// req_tready falls; no item is lost or repeated. Reset clears all valid flags,
// so the pipeline comes up empty with rsp_tvalid low.
module cubic_bezier_split import cbs_pkg::*; #(
   parameter int COORD_WIDTH = COORD_WIDTH_DEF,
   parameter int T_BITS = T_BITS_DEF
) (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   // Fields from bit 0 up: split_t, start_x, start_y, start_out_dx, start_out_dy,
   // end_x, end_y, end_in_dx, end_in_dy; zero padding to whole bytes.
   input  logic [((T_BITS + 1 + 8 * COORD_WIDTH + 7) / 8) * 8 - 1:0] req_tdata,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   // Fields from bit 0 up: mid_x, mid_y, mid_in_dx, mid_in_dy, mid_out_dx,
   // mid_out_dy; zero padding to whole bytes.
   output logic [((6 * COORD_WIDTH + 7) / 8) * 8 - 1:0] rsp_tdata
);

   localparam int VAL_W = COORD_WIDTH + 1;
   localparam int FIELD_BASE = T_BITS + 1;
   localparam int RSP_W = ((6 * COORD_WIDTH + 7) / 8) * 8;
   localparam int L1_LANES = 3 * AXES;
   localparam int L2_LANES = 2 * AXES;
   localparam int L3_LANES = AXES;
   localparam int L3_SIDE_W = 2 * AXES * VAL_W;

   logic [T_BITS:0]               req_t;
   logic signed [COORD_WIDTH-1:0] req_start [AXES];
   logic signed [COORD_WIDTH-1:0] req_start_out [AXES];
   logic signed [COORD_WIDTH-1:0] req_end_pt [AXES];
   logic signed [COORD_WIDTH-1:0] req_end_in [AXES];

   logic                    prep_valid, l1_ready;
   logic [T_BITS:0]         prep_t;
   logic signed [VAL_W-1:0] prep_p0 [AXES];
   logic signed [VAL_W-1:0] prep_c1 [AXES];
   logic signed [VAL_W-1:0] prep_c2 [AXES];
   logic signed [VAL_W-1:0] prep_p3 [AXES];

   logic                    l1_valid, l2_ready;
   logic signed [VAL_W-1:0] l1_a [L1_LANES];
   logic signed [VAL_W-1:0] l1_b [L1_LANES];
   logic signed [VAL_W-1:0] l1_res [L1_LANES];
   logic [T_BITS:0]         l1_t;

   logic                    l2_valid, l3_ready;
   logic signed [VAL_W-1:0] l2_a [L2_LANES];
   logic signed [VAL_W-1:0] l2_b [L2_LANES];
   logic signed [VAL_W-1:0] l2_res [L2_LANES];
   logic [T_BITS:0]         l2_t;

   logic                    l3_valid, sat_ready;
   logic signed [VAL_W-1:0] l3_a [L3_LANES];
   logic signed [VAL_W-1:0] l3_b [L3_LANES];
   logic signed [VAL_W-1:0] l3_res [L3_LANES];
   logic [L3_SIDE_W-1:0]    l3_side_in, l3_side_out;
   logic signed [VAL_W-1:0] l3_r0 [AXES];
   logic signed [VAL_W-1:0] l3_r1 [AXES];

   logic signed [COORD_WIDTH-1:0] out_pt [AXES];
   logic signed [COORD_WIDTH-1:0] out_din [AXES];
   logic signed [COORD_WIDTH-1:0] out_dout [AXES];

   // Unpack the request item.
   assign req_t = req_tdata[T_BITS:0];

   always_comb begin
      for (int ax = 0; ax < AXES; ax++) begin
         req_start[ax]     = $signed(req_tdata[FIELD_BASE + ax * COORD_WIDTH +: COORD_WIDTH]);
         req_start_out[ax] =
            $signed(req_tdata[FIELD_BASE + (2 + ax) * COORD_WIDTH +: COORD_WIDTH]);
         req_end_pt[ax]    =
            $signed(req_tdata[FIELD_BASE + (4 + ax) * COORD_WIDTH +: COORD_WIDTH]);
         req_end_in[ax]    =
            $signed(req_tdata[FIELD_BASE + (6 + ax) * COORD_WIDTH +: COORD_WIDTH]);
      end
   end

   // Absolute control points and clamped t.
   cbs_prep #(
      .COORD_WIDTH(COORD_WIDTH),
      .T_BITS     (T_BITS),
      .VAL_W      (VAL_W)
   ) u_prep (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (req_tvalid),
      .in_ready    (req_tready),
      .in_t        (req_t),
      .in_start    (req_start),
      .in_start_out(req_start_out),
      .in_end_pt   (req_end_pt),
      .in_end_in   (req_end_in),
      .out_valid   (prep_valid),
      .out_ready   (l1_ready),
      .out_t       (prep_t),
      .out_p0      (prep_p0),
      .out_c1      (prep_c1),
      .out_c2      (prep_c2),
      .out_p3      (prep_p3)
   );

   // First level: the three control polygon edges of each axis.
   always_comb begin
      for (int ax = 0; ax < AXES; ax++) begin
         l1_a[ax * 3]     = prep_p0[ax];
         l1_b[ax * 3]     = prep_c1[ax];
         l1_a[ax * 3 + 1] = prep_c1[ax];
         l1_b[ax * 3 + 1] = prep_c2[ax];
         l1_a[ax * 3 + 2] = prep_c2[ax];
         l1_b[ax * 3 + 2] = prep_p3[ax];
      end
   end

   cbs_lerp #(
      .VAL_W (VAL_W),
      .T_BITS(T_BITS),
      .LANES (L1_LANES),
      .SIDE_W(T_BITS + 1)
   ) u_level1 (
      .clock    (clock),
      .reset    (reset),
      .in_valid (prep_valid),
      .in_ready (l1_ready),
      .in_t     (prep_t),
      .in_a     (l1_a),
      .in_b     (l1_b),
      .in_side  (prep_t),
      .out_valid(l1_valid),
      .out_ready(l2_ready),
      .out_res  (l1_res),
      .out_side (l1_t)
   );

   // Second level: the two new handles of each axis.
   always_comb begin
      for (int ax = 0; ax < AXES; ax++) begin
         l2_a[ax * 2]     = l1_res[ax * 3];
         l2_b[ax * 2]     = l1_res[ax * 3 + 1];
         l2_a[ax * 2 + 1] = l1_res[ax * 3 + 1];
         l2_b[ax * 2 + 1] = l1_res[ax * 3 + 2];
      end
   end

   cbs_lerp #(
      .VAL_W (VAL_W),
      .T_BITS(T_BITS),
      .LANES (L2_LANES),
      .SIDE_W(T_BITS + 1)
   ) u_level2 (
      .clock    (clock),
      .reset    (reset),
      .in_valid (l1_valid),
      .in_ready (l2_ready),
      .in_t     (l1_t),
      .in_a     (l2_a),
      .in_b     (l2_b),
      .in_side  (l1_t),
      .out_valid(l2_valid),
      .out_ready(l3_ready),
      .out_res  (l2_res),
      .out_side (l2_t)
   );

   // Third level: the point on the curve; the handles ride along beside it.
   always_comb begin
      for (int ax = 0; ax < AXES; ax++) begin
         l3_a[ax] = l2_res[ax * 2];
         l3_b[ax] = l2_res[ax * 2 + 1];
         l3_side_in[ax * VAL_W +: VAL_W]          = l2_res[ax * 2];
         l3_side_in[(AXES + ax) * VAL_W +: VAL_W] = l2_res[ax * 2 + 1];
      end
   end

   cbs_lerp #(
      .VAL_W (VAL_W),
      .T_BITS(T_BITS),
      .LANES (L3_LANES),
      .SIDE_W(L3_SIDE_W)
   ) u_level3 (
      .clock    (clock),
      .reset    (reset),
      .in_valid (l2_valid),
      .in_ready (l3_ready),
      .in_t     (l2_t),
      .in_a     (l3_a),
      .in_b     (l3_b),
      .in_side  (l3_side_in),
      .out_valid(l3_valid),
      .out_ready(sat_ready),
      .out_res  (l3_res),
      .out_side (l3_side_out)
   );

   always_comb begin
      for (int ax = 0; ax < AXES; ax++) begin
         l3_r0[ax] = $signed(l3_side_out[ax * VAL_W +: VAL_W]);
         l3_r1[ax] = $signed(l3_side_out[(AXES + ax) * VAL_W +: VAL_W]);
      end
   end

   // Offsets, saturation and the response register.
   cbs_sat #(
      .COORD_WIDTH(COORD_WIDTH),
      .VAL_W      (VAL_W)
   ) u_sat (
      .clock    (clock),
      .reset    (reset),
      .in_valid (l3_valid),
      .in_ready (sat_ready),
      .in_mid   (l3_res),
      .in_r0    (l3_r0),
      .in_r1    (l3_r1),
      .out_valid(rsp_tvalid),
      .out_ready(rsp_tready),
      .out_pt   (out_pt),
      .out_din  (out_din),
      .out_dout (out_dout)
   );

   // Pack the response item.
   assign rsp_tdata = RSP_W'({out_dout[AXIS_Y], out_dout[AXIS_X],
                              out_din[AXIS_Y], out_din[AXIS_X],
                              out_pt[AXIS_Y], out_pt[AXIS_X]});

endmodule

// File: rtl/cbs_prep.sv
module cbs_prep import cbs_pkg::*; #(
   parameter int COORD_WIDTH = COORD_WIDTH_DEF,
   parameter int T_BITS = T_BITS_DEF,
   parameter int VAL_W = COORD_WIDTH + 1
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  logic [T_BITS:0]               in_t,
   input  logic signed [COORD_WIDTH-1:0] in_start [AXES],
   input  logic signed [COORD_WIDTH-1:0] in_start_out [AXES],
   input  logic signed [COORD_WIDTH-1:0] in_end_pt [AXES],
   input  logic signed [COORD_WIDTH-1:0] in_end_in [AXES],
   output logic                          out_valid,
   input  logic                          out_ready,
   output logic [T_BITS:0]               out_t,
   output logic signed [VAL_W-1:0]       out_p0 [AXES],
   output logic signed [VAL_W-1:0]       out_c1 [AXES],
   output logic signed [VAL_W-1:0]       out_c2 [AXES],
   output logic signed [VAL_W-1:0]       out_p3 [AXES]
);

   localparam logic [T_BITS:0] T_ONE = (T_BITS + 1)'(1) << T_BITS;

   logic                   valid_ff, valid_in;
   logic [T_BITS:0]        t_ff, t_in;
   logic signed [VAL_W-1:0] p0_ff [AXES];
   logic signed [VAL_W-1:0] c1_ff [AXES];
   logic signed [VAL_W-1:0] c2_ff [AXES];
   logic signed [VAL_W-1:0] p3_ff [AXES];
   logic signed [VAL_W-1:0] p0_in [AXES];
   logic signed [VAL_W-1:0] c1_in [AXES];
   logic signed [VAL_W-1:0] c2_in [AXES];
   logic signed [VAL_W-1:0] p3_in [AXES];

   // The stage takes a new item whenever it is empty or its item moves on.
   assign in_ready = !valid_ff || out_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   // A parameter above one is clamped to exactly one.
   always_comb begin
      if (in_t > T_ONE) begin
         t_in = T_ONE;
      end else begin
         t_in = in_t;
      end
   end

   // Handle offsets become absolute control points, one bit wider than a coordinate.
   always_comb begin
      for (int ax = 0; ax < AXES; ax++) begin
         p0_in[ax] = VAL_W'(in_start[ax]);
         p3_in[ax] = VAL_W'(in_end_pt[ax]);
         c1_in[ax] = VAL_W'(in_start[ax]) + VAL_W'(in_start_out[ax]);
         c2_in[ax] = VAL_W'(in_end_pt[ax]) + VAL_W'(in_end_in[ax]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         t_ff  <= t_in;
         p0_ff <= p0_in;
         c1_ff <= c1_in;
         c2_ff <= c2_in;
         p3_ff <= p3_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_t     = t_ff;
   assign out_p0    = p0_ff;
   assign out_c1    = c1_ff;
   assign out_c2    = c2_ff;
   assign out_p3    = p3_ff;

endmodule

// File: rtl/cbs_lerp.sv
module cbs_lerp import cbs_pkg::*; #(
   parameter int VAL_W = COORD_WIDTH_DEF + 1,
   parameter int T_BITS = T_BITS_DEF,
   parameter int LANES = 3 * AXES,
   parameter int SIDE_W = T_BITS_DEF + 1
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   output logic                    in_ready,
   input  logic [T_BITS:0]         in_t,
   input  logic signed [VAL_W-1:0] in_a [LANES],
   input  logic signed [VAL_W-1:0] in_b [LANES],
   input  logic [SIDE_W-1:0]       in_side,
   output logic                    out_valid,
   input  logic                    out_ready,
   output logic signed [VAL_W-1:0] out_res [LANES],
   output logic [SIDE_W-1:0]       out_side
);

   // Difference of two points and its product with t.
   localparam int DIFF_W = VAL_W + 1;
   localparam int PROD_W = DIFF_W + T_BITS + 2;

   logic                     a_valid_ff, a_valid_in, a_ready;
   logic                     b_valid_ff, b_valid_in, b_ready;
   logic signed [VAL_W-1:0]  a_base_ff [LANES];
   logic signed [PROD_W-1:0] a_prod_ff [LANES];
   logic [SIDE_W-1:0]        a_side_ff;
   logic signed [VAL_W-1:0]  b_res_ff [LANES];
   logic [SIDE_W-1:0]        b_side_ff;
   logic signed [DIFF_W-1:0] diff [LANES];
   logic signed [PROD_W-1:0] prod [LANES];
   logic signed [VAL_W-1:0]  res [LANES];
   logic signed [T_BITS+1:0] t_signed;

   // Ready runs backward through both stages; a stage holds its item while stalled.
   assign b_ready    = !b_valid_ff || out_ready;
   assign a_ready    = !a_valid_ff || b_ready;
   assign in_ready   = a_ready;
   assign a_valid_in = a_ready ? in_valid : a_valid_ff;
   assign b_valid_in = b_ready ? a_valid_ff : b_valid_ff;

   // First stage: difference of the two points times t.
   assign t_signed = $signed({1'b0, in_t});

   always_comb begin
      for (int i = 0; i < LANES; i++) begin
         diff[i] = DIFF_W'(in_b[i]) - DIFF_W'(in_a[i]);
         prod[i] = PROD_W'(diff[i]) * PROD_W'(t_signed);
      end
   end

   // Second stage: the floored step is an arithmetic shift, added to the first point.
   // The sum lies between the two points, so it fits the point width.
   always_comb begin
      for (int i = 0; i < LANES; i++) begin
         res[i] = a_base_ff[i] + VAL_W'(a_prod_ff[i] >>> T_BITS);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= a_valid_in;
         b_valid_ff <= b_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (a_ready && in_valid) begin
         a_base_ff <= in_a;
         a_prod_ff <= prod;
         a_side_ff <= in_side;
      end
   end

   always_ff @(posedge clock) begin
      if (b_ready && a_valid_ff) begin
         b_res_ff  <= res;
         b_side_ff <= a_side_ff;
      end
   end

   assign out_valid = b_valid_ff;
   assign out_res   = b_res_ff;
   assign out_side  = b_side_ff;

endmodule

// File: rtl/cbs_sat.sv
module cbs_sat import cbs_pkg::*; #(
   parameter int COORD_WIDTH = COORD_WIDTH_DEF,
   parameter int VAL_W = COORD_WIDTH + 1
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  logic signed [VAL_W-1:0]       in_mid [AXES],
   input  logic signed [VAL_W-1:0]       in_r0 [AXES],
   input  logic signed [VAL_W-1:0]       in_r1 [AXES],
   output logic                          out_valid,
   input  logic                          out_ready,
   output logic signed [COORD_WIDTH-1:0] out_pt [AXES],
   output logic signed [COORD_WIDTH-1:0] out_din [AXES],
   output logic signed [COORD_WIDTH-1:0] out_dout [AXES]
);

   localparam int DIFF_W = VAL_W + 1;
   localparam logic signed [COORD_WIDTH-1:0] COORD_MAX = {1'b0, {(COORD_WIDTH - 1){1'b1}}};
   localparam logic signed [COORD_WIDTH-1:0] COORD_MIN = {1'b1, {(COORD_WIDTH - 1){1'b0}}};

   logic                          valid_ff, valid_in;
   logic signed [COORD_WIDTH-1:0] pt_ff [AXES];
   logic signed [COORD_WIDTH-1:0] din_ff [AXES];
   logic signed [COORD_WIDTH-1:0] dout_ff [AXES];
   logic signed [COORD_WIDTH-1:0] pt_in [AXES];
   logic signed [COORD_WIDTH-1:0] din_in [AXES];
   logic signed [COORD_WIDTH-1:0] dout_in [AXES];

   // Clamp a wide value into the coordinate range: it fits when all bits above
   // the coordinate's sign bit equal that sign bit.
   function automatic logic signed [COORD_WIDTH-1:0] saturate(
      input logic signed [DIFF_W-1:0] v
   );
      logic [DIFF_W-COORD_WIDTH:0] top;
      top = v[DIFF_W-1:COORD_WIDTH-1];
      if ((&top) || !(|top)) begin
         return v[COORD_WIDTH-1:0];
      end else if (v[DIFF_W-1]) begin
         return COORD_MIN;
      end else begin
         return COORD_MAX;
      end
   endfunction

   // Output register: new handles as offsets from the point on the curve.
   assign in_ready = !valid_ff || out_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   always_comb begin
      for (int ax = 0; ax < AXES; ax++) begin
         pt_in[ax]   = saturate(DIFF_W'(in_mid[ax]));
         din_in[ax]  = saturate(DIFF_W'(in_r0[ax]) - DIFF_W'(in_mid[ax]));
         dout_in[ax] = saturate(DIFF_W'(in_r1[ax]) - DIFF_W'(in_mid[ax]));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         pt_ff   <= pt_in;
         din_ff  <= din_in;
         dout_ff <= dout_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_pt    = pt_ff;
   assign out_din   = din_ff;
   assign out_dout  = dout_ff;

endmodule
